### hw/rtl/quantized_max_pool_2d_core_macros.svh
// quantized_max_pool_2d_core_macros.svh
// assertion macros for the max pooling core; no other dependencies
`ifndef QUANTIZED_MAX_POOL_2D_CORE_MACROS_SVH
`define QUANTIZED_MAX_POOL_2D_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define QMP_ASSERT(lbl, clock, reset, prop, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define QMP_ASSERT_ALWAYS(lbl, clock, prop, msg) \
  lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define QMP_ASSERT(lbl, clock, reset, prop, msg)
`define QMP_ASSERT_ALWAYS(lbl, clock, prop, msg)
`endif

`endif

### hw/rtl/qmp_pkg.sv
// qmp_pkg.sv
// shared types, constants and microcode table of the max pooling core
// no dependencies
`timescale 1ns / 1ps

package qmp_pkg;

  localparam int MAX_CHANNELS_DEF = 16;
  localparam int MAX_WIDTH_DEF    = 64;
  localparam int MAX_HEIGHT_DEF   = 64;
  localparam int MAX_WINDOW_DEF   = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int COORD_W    = 12;
  localparam int STEP_W     = 3;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STRIDE        = 3'd0,
    REG_PAD_LEFT      = 3'd1,
    REG_PAD_TOP       = 3'd2,
    REG_WINDOW_WIDTH  = 3'd3,
    REG_WINDOW_HEIGHT = 3'd4,
    REG_IN_WIDTH      = 3'd5,
    REG_IN_HEIGHT     = 3'd6,
    REG_CLAMP_BOUNDS  = 3'd7
  } reg_idx_t;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE   = 3'd0;
  localparam step_t STEP_DECODE = 3'd1;
  localparam step_t STEP_READ   = 3'd2;
  localparam step_t STEP_FINAL  = 3'd3;
  localparam step_t STEP_OUT    = 3'd7;

  typedef enum logic [2:0] {
    JMP_NEXT     = 3'd0,
    JMP_ALWAYS   = 3'd1,
    JMP_NO_REQ   = 3'd2,
    JMP_IF_WRITE = 3'd3,
    JMP_NOT_DONE = 3'd4,
    JMP_OUT_BUSY = 3'd5
  } jmp_t;

  typedef struct packed {
    logic  take_in;
    logic  do_decode;
    logic  do_read;
    logic  do_out;
    jmp_t  jmp;
    step_t target;
  } ctrl_word_t;

  // microcode: one control word per step
  function automatic ctrl_word_t ucode_rom(step_t s);
    ctrl_word_t w;
    w = '{take_in: 1'b0, do_decode: 1'b0, do_read: 1'b0, do_out: 1'b0,
          jmp: JMP_ALWAYS, target: STEP_IDLE};
    case (s)
      STEP_IDLE: begin
        w.take_in = 1'b1;
        w.jmp     = JMP_NO_REQ;
        w.target  = STEP_IDLE;
      end
      STEP_DECODE: begin
        w.do_decode = 1'b1;
        w.jmp       = JMP_IF_WRITE;
        w.target    = STEP_IDLE;
      end
      STEP_READ: begin
        w.do_read = 1'b1;
        w.jmp     = JMP_NOT_DONE;
        w.target  = STEP_READ;
      end
      STEP_FINAL: begin
        w.jmp    = JMP_ALWAYS;
        w.target = STEP_OUT;
      end
      STEP_OUT: begin
        // falls through to idle by wraparound once the result is loaded
        w.do_out = 1'b1;
        w.jmp    = JMP_OUT_BUSY;
        w.target = STEP_OUT;
      end
      default: begin
        w.jmp    = JMP_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

### hw/rtl/qmp_req_if.sv
// qmp_req_if.sv
// request channel of the max pooling core: write or query item
// depends on nothing
`timescale 1ns / 1ps

interface qmp_req_if;
  logic       valid;
  logic       ready;
  logic [0:0] op;
  logic [3:0] channel;
  logic [5:0] col;
  logic [5:0] row;
  logic [7:0] pixel;

  modport source (output valid, op, channel, col, row, pixel, input ready);
  modport sink (input valid, op, channel, col, row, pixel, output ready);
endinterface

### hw/rtl/qmp_rsp_if.sv
// qmp_rsp_if.sv
// result channel of the max pooling core: pooled value
// depends on nothing
`timescale 1ns / 1ps

interface qmp_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] pooled_value;

  modport source (output valid, pooled_value, input ready);
  modport sink (input valid, pooled_value, output ready);
endinterface

### hw/rtl/quantized_max_pool_2d_core.sv
// Uint8 max pooling core. A write request stores one byte in the tile memory and gives no
// result; a query request scans its window through the single read port of the tile memory,
// one window position per cycle, and returns the clamped maximum. A write passes through
// the decode step, which stores the byte, and returns to idle for the next request. A query
// passes through the decode, read, final and output steps; the output step waits while the
// previous result still waits on the result channel. A finished result sits in an output
// register, so the next request is taken while it waits. The tile memory is not cleared after
// reset; reading an entry never written returns an arbitrary byte.
// Depends on qmp_pkg, qmp_req_if, qmp_rsp_if and quantized_max_pool_2d_core_macros.svh.
`timescale 1ns / 1ps

`include "quantized_max_pool_2d_core_macros.svh"

module quantized_max_pool_2d_core
  import qmp_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT   = MAX_HEIGHT_DEF,
  parameter int MAX_WINDOW   = MAX_WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  qmp_req_if.sink               req,
  qmp_rsp_if.source             rsp
);

  localparam int DEPTH  = MAX_CHANNELS * MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration
  logic [3:0]  stride;
  logic [3:0]  pad_left;
  logic [3:0]  pad_top;
  logic [4:0]  window_width;
  logic [4:0]  window_height;
  logic [6:0]  in_width;
  logic [6:0]  in_height;
  logic [15:0] clamp_bounds;

  always_ff @(posedge clk) begin
    if (rst) begin
      stride        <= 4'd1;
      pad_left      <= 4'd0;
      pad_top       <= 4'd0;
      window_width  <= 5'd2;
      window_height <= 5'd2;
      in_width      <= 7'd64;
      in_height     <= 7'd64;
      clamp_bounds  <= 16'hFF00;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_STRIDE:        stride        <= cfg_data[3:0];
        REG_PAD_LEFT:      pad_left      <= cfg_data[3:0];
        REG_PAD_TOP:       pad_top       <= cfg_data[3:0];
        REG_WINDOW_WIDTH:  window_width  <= cfg_data[4:0];
        REG_WINDOW_HEIGHT: window_height <= cfg_data[4:0];
        REG_IN_WIDTH:      in_width      <= cfg_data[6:0];
        REG_IN_HEIGHT:     in_height     <= cfg_data[6:0];
        REG_CLAMP_BOUNDS:  clamp_bounds  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [4:0] ww_cap;
  logic [4:0] wh_cap;
  logic [6:0] iw_cap;
  logic [6:0] ih_cap;

  assign ww_cap = (32'(window_width) > MAX_WINDOW) ? 5'(MAX_WINDOW) : window_width;
  assign wh_cap = (32'(window_height) > MAX_WINDOW) ? 5'(MAX_WINDOW) : window_height;
  assign iw_cap = (32'(in_width) > MAX_WIDTH) ? 7'(MAX_WIDTH) : in_width;
  assign ih_cap = (32'(in_height) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : in_height;

  // sequencer
  step_t      pc;
  step_t      pc_next;
  ctrl_word_t cw;
  logic       req_fire;
  logic       done;

  assign cw       = ucode_rom(pc);
  assign req.ready = cw.take_in;
  assign req_fire = req.valid && cw.take_in;

  // request latch
  logic [0:0] req_op;
  logic [3:0] req_channel;
  logic [5:0] req_col;
  logic [5:0] req_row;
  logic [7:0] req_pixel;

  always_ff @(posedge clk) begin
    if (req_fire) begin
      req_op      <= req.op;
      req_channel <= req.channel;
      req_col     <= req.col;
      req_row     <= req.row;
      req_pixel   <= req.pixel;
    end
  end

  logic out_valid;
  logic [7:0] out_value;

  always_comb begin
    case (cw.jmp)
      JMP_NEXT:     pc_next = pc + 1'b1;
      JMP_ALWAYS:   pc_next = cw.target;
      JMP_NO_REQ:   pc_next = req_fire ? pc + 1'b1 : cw.target;
      JMP_IF_WRITE: pc_next = (req_op == OP_WRITE) ? cw.target : pc + 1'b1;
      JMP_NOT_DONE: pc_next = done ? pc + 1'b1 : cw.target;
      JMP_OUT_BUSY: pc_next = (out_valid && !rsp.ready) ? cw.target : pc + 1'b1;
      default:      pc_next = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // window walk
  logic signed [COORD_W-1:0] x0;
  logic signed [COORD_W-1:0] y0;
  logic [4:0] dx;
  logic [4:0] dy;
  logic [9:0] col_prod;
  logic [9:0] row_prod;
  logic signed [COORD_W-1:0] x;
  logic signed [COORD_W-1:0] y;
  logic ch_ok;
  logic empty;
  logic dx_last;
  logic dy_last;
  logic pos_hit;

  assign col_prod = 10'(req_col) * 10'(stride);
  assign row_prod = 10'(req_row) * 10'(stride);
  assign x = x0 + signed'(COORD_W'(dx));
  assign y = y0 + signed'(COORD_W'(dy));
  assign ch_ok = 32'(req_channel) < MAX_CHANNELS;
  assign empty = (ww_cap == 5'd0) || (wh_cap == 5'd0);
  assign dx_last = (6'(dx) + 6'd1) >= 6'(ww_cap);
  assign dy_last = (6'(dy) + 6'd1) >= 6'(wh_cap);
  assign done = empty || (dx_last && dy_last);
  assign pos_hit = ch_ok && !empty
                && !x[COORD_W-1] && (x < signed'(COORD_W'(iw_cap)))
                && !y[COORD_W-1] && (y < signed'(COORD_W'(ih_cap)));

  always_ff @(posedge clk) begin
    if (cw.do_decode) begin
      x0 <= signed'(COORD_W'(col_prod)) - signed'(COORD_W'(pad_left));
      y0 <= signed'(COORD_W'(row_prod)) - signed'(COORD_W'(pad_top));
      dx <= 5'd0;
      dy <= 5'd0;
    end else if (cw.do_read) begin
      if (dx_last) begin
        dx <= 5'd0;
        dy <= dy + 5'd1;
      end else begin
        dx <= dx + 5'd1;
      end
    end
  end

  // tile memory
  logic [7:0] tile_mem [DEPTH];
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic wr_ok;
  logic mem_we;
  logic [7:0] rd_data;
  logic hit;

  assign wr_addr = ADDR_W'((32'(req_channel) * MAX_HEIGHT + 32'(req_row)) * MAX_WIDTH
                           + 32'(req_col));
  assign rd_addr = ADDR_W'((32'(req_channel) * MAX_HEIGHT + 32'(unsigned'(y))) * MAX_WIDTH
                           + 32'(unsigned'(x)));
  assign wr_ok = (32'(req_channel) < MAX_CHANNELS) && (32'(req_col) < MAX_WIDTH)
              && (32'(req_row) < MAX_HEIGHT);
  assign mem_we = cw.do_decode && (req_op == OP_WRITE) && wr_ok;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tile_mem[wr_addr] <= req_pixel;
    end
    rd_data <= tile_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else begin
      hit <= cw.do_read && pos_hit;
    end
  end

  // running maximum
  logic [7:0] best;

  always_ff @(posedge clk) begin
    if (cw.do_decode) begin
      best <= 8'd0;
    end else if (hit && (rd_data > best)) begin
      best <= rd_data;
    end
  end

  // clamp and result register
  logic [7:0] lo;
  logic [7:0] hi;
  logic [7:0] raised;
  logic [7:0] clamped;

  assign lo      = clamp_bounds[7:0];
  assign hi      = clamp_bounds[15:8];
  assign raised  = (best < lo) ? lo : best;
  assign clamped = (raised > hi) ? hi : raised;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cw.do_out && (!out_valid || rsp.ready)) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.do_out && (!out_valid || rsp.ready)) begin
      out_value <= clamped;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.pooled_value = out_value;

  `QMP_ASSERT(a_write_only_for_write_op, clk, rst, mem_we |-> (req_op == OP_WRITE), "memory write on a query")
  `QMP_ASSERT(a_hit_follows_read, clk, rst, hit |-> $past(cw.do_read), "window hit without a read step")
  `QMP_ASSERT(a_walk_in_window, clk, rst, (cw.do_read && !empty) |-> (dx < ww_cap && dy < wh_cap), "window walk out of bounds")
  `QMP_ASSERT(a_pending_result_held, clk, rst, (out_valid && !rsp.ready && pc == STEP_OUT) |=> (pc == STEP_OUT && $stable(out_value)), "pending result overwritten")

endmodule

### bench/quantized_max_pool_2d_core_tb.sv
// quantized_max_pool_2d_core_tb.sv
// self-checking bench for the max pooling core: tile writes, window queries, clamp settings
// depends on qmp_pkg, qmp_req_if, qmp_rsp_if and quantized_max_pool_2d_core
`timescale 1ns / 1ps

module quantized_max_pool_2d_core_tb;
  import qmp_pkg::*;

  localparam int TILE_ENTRIES    = MAX_CHANNELS_DEF * MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
  localparam int NUM_PHASES      = 13;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int SETTLE_CYCLES   = 300;
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT  = 20000;

  class pool_tracker;
    logic [7:0]  tile_bytes [TILE_ENTRIES];
    bit          tile_written [TILE_ENTRIES];
    logic [15:0] regs [8];
    logic [7:0]  pending_pooled [$];
    int          mismatch_count;

    function new();
      regs[REG_STRIDE]        = 16'd1;
      regs[REG_PAD_LEFT]      = 16'd0;
      regs[REG_PAD_TOP]       = 16'd0;
      regs[REG_WINDOW_WIDTH]  = 16'd2;
      regs[REG_WINDOW_HEIGHT] = 16'd2;
      regs[REG_IN_WIDTH]      = 16'd64;
      regs[REG_IN_HEIGHT]     = 16'd64;
      regs[REG_CLAMP_BOUNDS]  = 16'hFF00;
      mismatch_count = 0;
    endfunction

    static function logic [15:0] field_mask(reg_idx_t idx);
      case (idx)
        REG_STRIDE, REG_PAD_LEFT, REG_PAD_TOP: return 16'h000F;
        REG_WINDOW_WIDTH, REG_WINDOW_HEIGHT: return 16'h001F;
        REG_IN_WIDTH, REG_IN_HEIGHT: return 16'h007F;
        default: return 16'hFFFF;
      endcase
    endfunction

    function void set_register(reg_idx_t idx, logic [15:0] data);
      regs[idx] = data & field_mask(idx);
    endfunction

    function void window_origin(int ocol, int orow,
                                output int x0, output int y0, output int ww, output int wh,
                                output int iw, output int ih);
      x0 = ocol * int'(regs[REG_STRIDE]) - int'(regs[REG_PAD_LEFT]);
      y0 = orow * int'(regs[REG_STRIDE]) - int'(regs[REG_PAD_TOP]);
      ww = (regs[REG_WINDOW_WIDTH] > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF
                                                     : int'(regs[REG_WINDOW_WIDTH]);
      wh = (regs[REG_WINDOW_HEIGHT] > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF
                                                      : int'(regs[REG_WINDOW_HEIGHT]);
      iw = (regs[REG_IN_WIDTH] > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(regs[REG_IN_WIDTH]);
      ih = (regs[REG_IN_HEIGHT] > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(regs[REG_IN_HEIGHT]);
    endfunction

    // max over the inside positions; positions never written are listed instead
    function void scan_window(int ch, int ocol, int orow, output int best, ref int unwritten[$]);
      int x0, y0, ww, wh, iw, ih, x, y, addr;
      window_origin(ocol, orow, x0, y0, ww, wh, iw, ih);
      best = 0;
      for (int dy = 0; dy < wh; dy++) begin
        y = y0 + dy;
        if (y < 0 || y >= ih) continue;
        for (int dx = 0; dx < ww; dx++) begin
          x = x0 + dx;
          if (x < 0 || x >= iw) continue;
          addr = (ch * MAX_HEIGHT_DEF + y) * MAX_WIDTH_DEF + x;
          if (!tile_written[addr]) unwritten.push_back(addr);
          else if (tile_bytes[addr] > best) best = tile_bytes[addr];
        end
      end
    endfunction

    function void note_request(op_t op, int ch, int col, int row, logic [7:0] pix);
      int addr, best;
      int unwritten[$];
      int lo, hi;
      if (op == OP_WRITE) begin
        addr = (ch * MAX_HEIGHT_DEF + row) * MAX_WIDTH_DEF + col;
        tile_bytes[addr]   = pix;
        tile_written[addr] = 1'b1;
      end else begin
        scan_window(ch, col, row, best, unwritten);
        lo = regs[REG_CLAMP_BOUNDS][7:0];
        hi = regs[REG_CLAMP_BOUNDS][15:8];
        if (best < lo) best = lo;
        if (best > hi) best = hi;
        pending_pooled.push_back(8'(best));
      end
    endfunction

    task report_mismatch(string msg);
      mismatch_count++;
      $display("%0t: %s", $time, msg);
    endtask

    task check_pooled(logic [7:0] got);
      logic [7:0] want;
      if (pending_pooled.size() == 0) begin
        report_mismatch($sformatf("pooled_value %0d with no query pending", got));
      end else begin
        want = pending_pooled.pop_front();
        if (got !== want)
          report_mismatch($sformatf("pooled_value %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  qmp_req_if req_ch ();
  qmp_rsp_if rsp_ch ();

  pool_tracker sb;
  int          accepted_items;
  int          send_idle_pct;
  int          stall_pct;
  int          rsp_hold;

  quantized_max_pool_2d_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random stalls plus a single long hold-off
  initial begin : result_sink
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rsp_hold > 0) begin
        rsp_ch.ready = 1'b0;
        rsp_hold--;
      end else begin
        rsp_ch.ready = ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) sb.check_pooled(rsp_ch.pooled_value);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  task automatic send_item(op_t op, int ch, int col, int row, logic [7:0] pix);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.op      = op;
    req_ch.channel = 4'(ch);
    req_ch.col     = 6'(col);
    req_ch.row     = 6'(row);
    req_ch.pixel   = pix;
    req_ch.valid   = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(op, ch, col, row, pix);
    accepted_items++;
  endtask

  // any window entry not yet written gets a random byte first
  task automatic send_query(int ch, int ocol, int orow);
    int unwritten[$];
    int best;
    sb.scan_window(ch, ocol, orow, best, unwritten);
    foreach (unwritten[i])
      send_item(OP_WRITE, ch, unwritten[i] % MAX_WIDTH_DEF,
                (unwritten[i] / MAX_WIDTH_DEF) % MAX_HEIGHT_DEF, 8'($urandom));
    send_item(OP_QUERY, ch, ocol, orow, 8'($urandom));
  endtask

  task automatic write_register(reg_idx_t idx, logic [15:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    sb.set_register(idx, data);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (sb.pending_pooled.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure_phase(int phase);
    int          vals [8];
    bit          junk;
    logic [15:0] mask;
    junk = 1'b0;
    case (phase)
      1: vals = '{15, 15, 15, 31, 31, 127, 127, 'hFF00};
      2: vals = '{1, 0, 0, 1, 1, 1, 1, 'hFF00};
      3: vals = '{0, 2, 1, 3, 0, 64, 64, 'h30C0};
      4: vals = '{4, 0, 0, 5, 5, 64, 64, 'hE020};
      default: begin
        vals[0] = ($urandom_range(0, 9) == 0) ? 0
                  : $urandom_range(1, ($urandom_range(0, 3) == 0) ? 15 : 4);
        vals[1] = $urandom_range(0, ($urandom_range(0, 1) == 0) ? 15 : 2);
        vals[2] = $urandom_range(0, ($urandom_range(0, 1) == 0) ? 15 : 2);
        vals[3] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4);
        vals[4] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4);
        vals[5] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64);
        vals[6] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64);
        case ($urandom_range(0, 4))
          0, 1: vals[7] = 'hFF00;
          2: vals[7] = $urandom_range(0, 'hFFFF);
          3: vals[7] = ($urandom_range(128, 255) << 8) | $urandom_range(0, 127);
          default: vals[7] = ($urandom_range(0, 1) == 0) ? 'hFFFF : 'h0000;
        endcase
        junk = ($urandom_range(0, 3) == 0);
      end
    endcase
    for (int i = 0; i < 8; i++) begin
      mask = pool_tracker::field_mask(reg_idx_t'(i));
      write_register(reg_idx_t'(i),
                     (16'(vals[i]) & mask) | (junk ? (16'($urandom) & ~mask) : 16'h0000));
    end
  endtask

  task automatic random_step();
    int pick, ch, ocol, orow, st, lim, x0, y0, ww, wh, iw, ih, x, y;
    pick = $urandom_range(0, 99);
    ch   = $urandom_range(0, MAX_CHANNELS_DEF - 1);
    if (pick < 60) begin
      // query aimed at the valid area, with a few fresh bytes in its window
      st = sb.regs[REG_STRIDE];
      iw = (sb.regs[REG_IN_WIDTH] > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(sb.regs[REG_IN_WIDTH]);
      ih = (sb.regs[REG_IN_HEIGHT] > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF
                                                      : int'(sb.regs[REG_IN_HEIGHT]);
      if (st == 0) begin
        ocol = $urandom_range(0, MAX_WIDTH_DEF - 1);
        orow = $urandom_range(0, MAX_HEIGHT_DEF - 1);
      end else begin
        lim  = (iw + int'(sb.regs[REG_PAD_LEFT])) / st;
        ocol = $urandom_range(0, (lim > MAX_WIDTH_DEF - 1) ? MAX_WIDTH_DEF - 1 : lim);
        lim  = (ih + int'(sb.regs[REG_PAD_TOP])) / st;
        orow = $urandom_range(0, (lim > MAX_HEIGHT_DEF - 1) ? MAX_HEIGHT_DEF - 1 : lim);
      end
      sb.window_origin(ocol, orow, x0, y0, ww, wh, iw, ih);
      if (ww > 0 && wh > 0) begin
        repeat ($urandom_range(0, 4)) begin
          x = x0 + $urandom_range(0, ww - 1);
          y = y0 + $urandom_range(0, wh - 1);
          if (x >= 0 && x < MAX_WIDTH_DEF && y >= 0 && y < MAX_HEIGHT_DEF)
            send_item(OP_WRITE, ch, x, y, 8'($urandom));
        end
      end
      send_query(ch, ocol, orow);
    end else if (pick < 80) begin
      send_item(OP_WRITE, ch, $urandom_range(0, MAX_WIDTH_DEF - 1),
                $urandom_range(0, MAX_HEIGHT_DEF - 1), 8'($urandom));
    end else begin
      send_query(ch, $urandom_range(0, MAX_WIDTH_DEF - 1), $urandom_range(0, MAX_HEIGHT_DEF - 1));
    end
  endtask

  initial begin : stimulus
    int phase_end;
    sb             = new();
    accepted_items = 0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    rsp_hold       = 0;
    cfg_write      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    req_ch.valid   = 1'b0;
    req_ch.op      = OP_WRITE;
    req_ch.channel = '0;
    req_ch.col     = '0;
    req_ch.row     = '0;
    req_ch.pixel   = '0;
    rst            = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // corners of the tile at the reset settings
    send_item(OP_WRITE, 0, 0, 0, 8'h00);
    send_item(OP_WRITE, 15, 63, 63, 8'hFF);
    send_item(OP_WRITE, 15, 0, 63, 8'hA5);
    send_item(OP_WRITE, 0, 63, 0, 8'h5A);
    send_query(0, 0, 0);
    send_query(15, 63, 63);
    send_query(15, 62, 62);
    send_query(0, 62, 0);
    send_query(15, 0, 62);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) configure_phase(phase);
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 69;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 69;
        end
        default: begin
          send_idle_pct = 15;
          stall_pct     = 15;
        end
      endcase
      // backpressure until the input stalls
      if (phase == 5) rsp_hold = HOLD_CYCLES;
      phase_end = accepted_items + ITEMS_PER_PHASE;
      while (accepted_items < phase_end) random_step();
      drain();
    end

    if (sb.mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### quantized_max_pool_2d_core.f
+incdir+hw/rtl
hw/rtl/qmp_pkg.sv
hw/rtl/qmp_req_if.sv
hw/rtl/qmp_rsp_if.sv
hw/rtl/quantized_max_pool_2d_core.sv
bench/quantized_max_pool_2d_core_tb.sv
